>>> src/sha256_stream_hasher_top_defines.svh
// Assertion macros for the streaming SHA-256 hasher.
// Standalone header; included by the files that carry assertions.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// Same-cycle implication under a synchronous active-low reset.
`define SHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under a synchronous active-low reset.
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/shs_pkg.sv
// Shared types, constants and helper functions for the SHA-256 hasher.
// No dependencies; imported by every module of the block.
package shs_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Control from the sequencer to the round core.
    typedef struct packed {
        logic load;   // copy chaining words into the working registers
        logic step;   // run one compression round
        logic fold;   // add working registers into the chaining words
        logic init;   // return chaining words to the initial hash
    } shs_core_ctl_t;

    // Control from the sequencer to the message schedule window.
    typedef struct packed {
        logic push;   // shift one byte into the block
        logic step;   // advance the schedule by one word
    } shs_sched_ctl_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

>>> src/shs_msg_sched.sv
// Block buffer and message schedule of the SHA-256 hasher: a 16-word shift window.
// Depends on shs_pkg.
module shs_msg_sched (
    input  logic                    aclk,
    input  shs_pkg::shs_sched_ctl_t ctl,
    input  logic [7:0]              byte_in,
    output logic [31:0]             w_out
);
    import shs_pkg::*;

    logic [31:0] win_reg  [0:15];
    logic [31:0] win_next [0:15];
    logic [31:0] sig0;
    logic [31:0] sig1;
    logic [31:0] w_new;

    assign sig0  = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
    assign sig1  = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
    assign w_new = win_reg[0] + sig0 + win_reg[9] + sig1;
    assign w_out = win_reg[0];

    always_comb begin
        win_next = win_reg;
        if (ctl.push) begin
            // Byte-wide shift across the whole block, big-endian within each word
            for (int i = 0; i < 15; i++) begin
                win_next[i] = {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], byte_in};
        end else if (ctl.step) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = w_new;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

>>> src/shs_round_core.sv
// Shared SHA-256 round unit with working registers and chaining words.
// Depends on shs_pkg.
module shs_round_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  shs_pkg::shs_core_ctl_t ctl,
    input  logic [31:0]            k_in,
    input  logic [31:0]            w_in,
    input  logic [2:0]             word_sel,
    output logic [31:0]            digest_word
);
    import shs_pkg::*;

    logic [31:0] work_reg  [0:7];
    logic [31:0] work_next [0:7];
    logic [31:0] hash_reg  [0:7];
    logic [31:0] hash_next [0:7];

    assign digest_word = hash_reg[word_sel];

    always_comb begin
        logic [31:0] bs0;
        logic [31:0] bs1;
        logic [31:0] ch;
        logic [31:0] maj;
        logic [31:0] t1;
        bs1 = rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25);
        ch  = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        t1  = work_reg[7] + bs1 + ch + k_in + w_in;
        bs0 = rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        work_next = work_reg;
        hash_next = hash_reg;
        if (ctl.load) begin
            work_next = hash_reg;
        end else if (ctl.step) begin
            work_next[7] = work_reg[6];
            work_next[6] = work_reg[5];
            work_next[5] = work_reg[4];
            work_next[4] = work_reg[3] + t1;
            work_next[3] = work_reg[2];
            work_next[2] = work_reg[1];
            work_next[1] = work_reg[0];
            work_next[0] = t1 + bs0 + maj;
        end
        if (ctl.init) begin
            hash_next = INIT_HASH;
        end else if (ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                hash_next[i] = hash_reg[i] + work_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= INIT_HASH;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

>>> src/sha256_stream_hasher_top.sv
// Top level of the streaming SHA-256 hasher: sequencer, padding and byte counter.
// Depends on shs_pkg, shs_msg_sched, shs_round_core and the assertion macro header.
//
// Usage: the input channel (s_valid/s_ready) takes one item per handshake:
// s_op = 0 appends s_data_byte to the message, s_op = 1 closes the message.
// The 64th byte of a block starts the compression: 64 rounds of the shared
// round unit, one round per cycle, then a fold of the result into the
// chaining words; s_ready is low throughout. A close feeds the 64 - fill
// padding bytes through the same byte path, one per cycle, compresses, and
// repeats once more when fewer than eight bytes were free after the 0x80
// byte. The digest then appears on the result channel (m_valid/m_ready) as
// eight words, word 0 first, m_last on word 7.
// A stalled receiver simply holds the current digest word; the block stays
// busy until all eight are taken, then returns to the initial hash values.
// Reset (aresetn low, synchronous) empties the block and the byte counter
// and loads the initial hash values; no clearing pass is needed.
`include "sha256_stream_hasher_top_defines.svh"

module sha256_stream_hasher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last
);
    import shs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } shs_state_t;

    shs_state_t     state_reg, state_next;
    logic [5:0]     fill_reg, fill_next;
    logic [60:0]    count_reg, count_next;
    logic [5:0]     round_reg, round_next;
    logic [2:0]     idx_reg, idx_next;
    logic           closing_reg, closing_next;
    logic           lastblk_reg, lastblk_next;
    logic           first_reg, first_next;

    shs_core_ctl_t  core_ctl;
    shs_sched_ctl_t sched_ctl;
    logic [7:0]     wr_byte;
    logic [7:0]     pad_byte;
    logic [63:0]    len_bits;
    logic [63:0]    len_shift;
    logic [31:0]    w_word;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign m_word_index = idx_reg;
    assign m_last       = (idx_reg == 3'd7);

    // Length field, most significant byte at block offset 56
    assign len_bits  = {count_reg, 3'b000};
    assign len_shift = len_bits >> 6'({3'd7 - fill_reg[2:0], 3'b000});

    always_comb begin
        if (first_reg) begin
            pad_byte = PAD_BYTE;
        end else if (lastblk_reg && (fill_reg[5:3] == 3'b111)) begin
            pad_byte = len_shift[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign wr_byte = (state_reg == ST_PAD) ? pad_byte : s_data_byte;

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        closing_next = closing_reg;
        lastblk_next = lastblk_reg;
        first_next   = first_reg;
        core_ctl     = '0;
        sched_ctl    = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_op) begin
                        sched_ctl.push = 1'b1;
                        fill_next      = fill_reg + 6'd1;
                        count_next     = count_reg + 61'd1;
                        if (fill_reg == 6'd63) begin
                            core_ctl.load = 1'b1;
                            state_next    = ST_ROUND;
                        end
                    end else begin
                        // Length fits behind the 0x80 byte unless it lands in the last eight
                        closing_next = 1'b1;
                        first_next   = 1'b1;
                        lastblk_next = (fill_reg[5:3] != 3'b111);
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctl.push = 1'b1;
                fill_next      = fill_reg + 6'd1;
                first_next     = 1'b0;
                if (fill_reg == 6'd63) begin
                    core_ctl.load = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND: begin
                core_ctl.step  = 1'b1;
                sched_ctl.step = 1'b1;
                round_next     = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                core_ctl.fold = 1'b1;
                if (!closing_reg) begin
                    state_next = ST_IDLE;
                end else if (lastblk_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else begin
                    // Spill: pad one more block of zeros and the length
                    lastblk_next = 1'b1;
                    state_next   = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        core_ctl.init = 1'b1;
                        count_next    = '0;
                        closing_next  = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            count_reg   <= '0;
            round_reg   <= '0;
            idx_reg     <= '0;
            closing_reg <= 1'b0;
            lastblk_reg <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            closing_reg <= closing_next;
            lastblk_reg <= lastblk_next;
            first_reg   <= first_next;
        end
    end

    shs_msg_sched u_sched (
        .aclk    (aclk),
        .ctl     (sched_ctl),
        .byte_in (wr_byte),
        .w_out   (w_word)
    );

    shs_round_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (core_ctl),
        .k_in        (ROUND_K[round_reg]),
        .w_in        (w_word),
        .word_sel    (idx_reg),
        .digest_word (m_digest_word)
    );

    `SHS_ASSERT_NOW(a_ready_excl_valid, aclk, aresetn, s_ready, !m_valid,
        "input accepted while digest pending")
    `SHS_ASSERT_NEXT(a_round_end_fold, aclk, aresetn,
        (state_reg == ST_ROUND) && (round_reg == 6'd63), state_reg == ST_FOLD,
        "compression did not end after 64 rounds")
    `SHS_ASSERT_NEXT(a_block_start_empty, aclk, aresetn,
        (state_reg != ST_ROUND) && (state_next == ST_ROUND),
        (fill_reg == 6'd0) && (round_reg == 6'd0),
        "compression started on a partial block")
    `SHS_ASSERT_NEXT(a_last_word_restart, aclk, aresetn, m_valid && m_ready && m_last,
        s_ready && (count_reg == 61'd0) && !closing_reg,
        "hasher not back at message start after digest")

endmodule
